@@ src/rbs_pkg.sv @@
// Package for the ray versus box slab test: word types, widths, divider step.
// Used by rbs_slab_div and ray_box_slab_intersect_top.
package rbs_pkg;

  localparam int COORD_W    = 32;
  localparam int FRAC_BITS  = 16;
  localparam int HALF_W     = 31;
  // |(+-h - o)| < 2^32, shifted up by the fraction bits
  localparam int MAG_W      = 32;
  localparam int NUM_W      = MAG_W + FRAC_BITS;
  // signed slab distance: 48-bit magnitude plus sign plus compare headroom
  localparam int T_W        = NUM_W + 2;
  localparam int LANES      = 6;
  localparam int STEPS_PER  = 2;
  localparam int DIV_STAGES = NUM_W / STEPS_PER;
  localparam int PROD_W     = 2 * COORD_W;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  typedef struct packed {
    logic signed [COORD_W-1:0] origin_x;
    logic signed [COORD_W-1:0] origin_y;
    logic signed [COORD_W-1:0] origin_z;
    logic signed [COORD_W-1:0] direction_x;
    logic signed [COORD_W-1:0] direction_y;
    logic signed [COORD_W-1:0] direction_z;
    logic signed [COORD_W-1:0] t_min;
    logic signed [COORD_W-1:0] t_max;
  } ray_t;

  typedef struct packed {
    logic                      hit_found;
    logic signed [COORD_W-1:0] hit_distance;
    logic [1:0]                face_axis;
    logic                      normal_negative;
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic signed [COORD_W-1:0] point_z;
  } res_t;

  typedef struct packed {
    logic [MAG_W-1:0] rem;
    logic [NUM_W-1:0] num;
    logic [NUM_W-1:0] quo;
  } div_st_t;

  // One restoring division step: bring down the next dividend bit.
  function automatic div_st_t div_step(div_st_t s, logic [MAG_W-1:0] dv);
    logic [MAG_W:0]   r2;
    logic [MAG_W+1:0] diff;
    div_st_t          n;
    r2     = {s.rem, s.num[NUM_W-1]};
    diff   = {1'b0, r2} - {2'b00, dv};
    n.num  = {s.num[NUM_W-2:0], 1'b0};
    if (!diff[MAG_W+1]) begin
      n.rem = diff[MAG_W-1:0];
      n.quo = {s.quo[NUM_W-2:0], 1'b1};
    end else begin
      n.rem = r2[MAG_W-1:0];
      n.quo = {s.quo[NUM_W-2:0], 1'b0};
    end
    return n;
  endfunction

endpackage

@@ src/ray_box_slab_intersect_top.sv @@
// Top level of the ray versus origin-centered cube slab test.
// Depends on rbs_pkg and rbs_slab_div.
//
// Usage:
//   ray channel (ray_valid, ray_stall, ray): one ray word per accepted edge.
//   res channel (res_valid, res_stall, res): one result word per ray, in order.
//   half_we / half_data: write the cube half size while the block is idle.
// From the accepting edge to res_valid a ray passes through the load register
// and 24 divider stages (two quotient bits each, six lanes), then swap, three
// axis narrowing stages, face pick, multiply, and the add/saturate output
// register.
// Throughput is one ray per cycle while res_stall does not hold the pipeline;
// the 24-stage divider pipeline sets the latency.
// The pipeline moves as a whole: when the output register holds a word and
// res_stall is high, every stage holds and ray_stall is raised; nothing is
// dropped or repeated. Reset clears all valid bits and sets the half size
// to 1.0 (65536).
module ray_box_slab_intersect_top
  import rbs_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              ray_valid,
  output logic              ray_stall,
  input  ray_t              ray,
  output logic              res_valid,
  input  logic              res_stall,
  output res_t              res,
  input  logic              half_we,
  input  logic [HALF_W-1:0] half_data
);

  logic              adv;
  logic [HALF_W-1:0] half;

  logic                        dv_vld;
  ray_t                        dv_ray;
  logic                        dv_zmiss;
  logic [LANES-1:0]            dv_qneg;
  logic [LANES-1:0][NUM_W-1:0] dv_quo;

  // Global advance: hold everything while the output word is stalled
  assign adv       = !(res_valid && res_stall);
  assign ray_stall = !adv;

  // Half size register
  always_ff @(posedge clk) begin
    if (rst) begin
      half <= HALF_W'(65536);
    end else if (half_we) begin
      half <= half_data;
    end
  end

  rbs_slab_div u_div (
    .clk     (clk),
    .rst     (rst),
    .adv     (adv),
    .vld_i   (ray_valid),
    .ray_i   (ray),
    .half    (half),
    .vld_o   (dv_vld),
    .ray_o   (dv_ray),
    .zmiss_o (dv_zmiss),
    .qneg_o  (dv_qneg),
    .quo_o   (dv_quo)
  );

  // Valid bits for swap, axis x, y, z, pick, multiply stages
  logic [5:0] vld;

  // Stage 1: signed distances, ordered per axis
  logic signed [T_W-1:0] s1_t1 [3];
  logic signed [T_W-1:0] s1_t2 [3];
  logic                  s1_neg [3];
  logic                  s1_fv [3];
  logic signed [T_W-1:0] s1_lo, s1_hi;
  logic                  s1_zmiss;
  ray_t                  s1_ray;

  // Axis chain registers: index 0 after x, 1 after y, 2 after z
  logic signed [T_W-1:0] c_t1 [3][3];
  logic signed [T_W-1:0] c_t2 [3][3];
  logic                  c_neg [3][3];
  logic                  c_fv [3][3];
  logic signed [T_W-1:0] c_tf [3][3];
  logic                  c_fneg [3][3];
  logic signed [T_W-1:0] c_lo [3];
  logic signed [T_W-1:0] c_hi [3];
  logic                  c_zmiss [3];
  ray_t                  c_ray [3];

  // Pick stage registers
  logic                      p_hit;
  logic signed [COORD_W-1:0] p_t;
  logic [1:0]                p_axis;
  logic                      p_fneg;
  ray_t                      p_ray;

  // Multiply stage registers
  logic                      m_hit;
  logic signed [COORD_W-1:0] m_t;
  logic [1:0]                m_axis;
  logic                      m_fneg;
  logic signed [PROD_W-1:0]  m_prod [3];
  logic signed [COORD_W-1:0] m_o [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      res_valid <= 1'b0;
    end else if (adv) begin
      vld       <= {vld[4:0], dv_vld};
      res_valid <= vld[5];
    end
  end

  // Stage 1: apply sign, swap so that t1 <= t2
  always_ff @(posedge clk) begin
    logic signed [T_W-1:0] qa, qb;
    logic signed [COORD_W-1:0] d [3];
    if (adv) begin
      d[0] = dv_ray.direction_x; d[1] = dv_ray.direction_y; d[2] = dv_ray.direction_z;
      for (int a = 0; a < 3; a++) begin
        qa = $signed({2'b00, dv_quo[2*a]});
        qb = $signed({2'b00, dv_quo[2*a+1]});
        if (dv_qneg[2*a])   qa = -qa;
        if (dv_qneg[2*a+1]) qb = -qb;
        if (qb < qa) begin
          s1_t1[a]  <= qb;
          s1_t2[a]  <= qa;
          s1_neg[a] <= 1'b1;
        end else begin
          s1_t1[a]  <= qa;
          s1_t2[a]  <= qb;
          s1_neg[a] <= 1'b0;
        end
        s1_fv[a] <= (d[a] != '0);
      end
      s1_lo    <= T_W'(dv_ray.t_min);
      s1_hi    <= T_W'(dv_ray.t_max);
      s1_zmiss <= dv_zmiss;
      s1_ray   <= dv_ray;
    end
  end

  // Stages 2 to 4: narrow the window one axis per stage
  always_ff @(posedge clk) begin
    logic signed [T_W-1:0] lo, hi;
    logic signed [T_W-1:0] t1 [3];
    logic signed [T_W-1:0] t2 [3];
    logic                  ng [3];
    logic                  fv [3];
    logic signed [T_W-1:0] tf [3];
    logic                  fn [3];
    if (adv) begin
      for (int s = 0; s < 3; s++) begin
        if (s == 0) begin
          lo = s1_lo; hi = s1_hi;
          for (int a = 0; a < 3; a++) begin
            t1[a] = s1_t1[a]; t2[a] = s1_t2[a]; ng[a] = s1_neg[a]; fv[a] = s1_fv[a];
            tf[a] = '0; fn[a] = 1'b0;
          end
        end else begin
          lo = c_lo[s-1]; hi = c_hi[s-1];
          for (int a = 0; a < 3; a++) begin
            t1[a] = c_t1[s-1][a]; t2[a] = c_t2[s-1][a]; ng[a] = c_neg[s-1][a];
            fv[a] = c_fv[s-1][a]; tf[a] = c_tf[s-1][a]; fn[a] = c_fneg[s-1][a];
          end
        end
        if (fv[s]) begin
          if (t1[s] > lo) begin
            tf[s] = t1[s]; fn[s] = ng[s];
          end else begin
            tf[s] = t2[s]; fn[s] = !ng[s];
          end
          if (t1[s] > lo) lo = t1[s];
          if (t2[s] < hi) hi = t2[s];
        end
        for (int a = 0; a < 3; a++) begin
          c_t1[s][a] <= t1[a]; c_t2[s][a] <= t2[a]; c_neg[s][a] <= ng[a];
          c_fv[s][a] <= fv[a]; c_tf[s][a] <= tf[a]; c_fneg[s][a] <= fn[a];
        end
        c_lo[s]    <= lo;
        c_hi[s]    <= hi;
        c_zmiss[s] <= (s == 0) ? s1_zmiss : c_zmiss[s-1];
        c_ray[s]   <= (s == 0) ? s1_ray : c_ray[s-1];
      end
    end
  end

  // Stage 5: choose the face, low end first, then high end
  always_ff @(posedge clk) begin
    logic                  found;
    logic [1:0]            ax;
    logic signed [T_W-1:0] t;
    logic                  fn;
    if (adv) begin
      found = 1'b0; ax = AXIS_X; t = '0; fn = 1'b0;
      for (int a = 0; a < 3; a++) begin
        if (!found && c_fv[2][a] && c_tf[2][a] == c_lo[2]) begin
          found = 1'b1; ax = 2'(a); t = c_tf[2][a]; fn = c_fneg[2][a];
        end
      end
      for (int a = 0; a < 3; a++) begin
        if (!found && c_fv[2][a] && c_tf[2][a] == c_hi[2]) begin
          found = 1'b1; ax = 2'(a); t = c_tf[2][a]; fn = c_fneg[2][a];
        end
      end
      // chosen distance lies within the original window, so it fits a word
      p_hit  <= found && !c_zmiss[2] && (c_lo[2] < c_hi[2]);
      p_t    <= t[COORD_W-1:0];
      p_axis <= ax;
      p_fneg <= fn;
      p_ray  <= c_ray[2];
    end
  end

  // Stage 6: distance times direction
  always_ff @(posedge clk) begin
    if (adv) begin
      m_hit     <= p_hit;
      m_t       <= p_t;
      m_axis    <= p_axis;
      m_fneg    <= p_fneg;
      m_prod[0] <= p_t * p_ray.direction_x;
      m_prod[1] <= p_t * p_ray.direction_y;
      m_prod[2] <= p_t * p_ray.direction_z;
      m_o[0]    <= p_ray.origin_x;
      m_o[1]    <= p_ray.origin_y;
      m_o[2]    <= p_ray.origin_z;
    end
  end

  // Stage 7: floor, add origin, saturate; zero the word on a miss
  always_ff @(posedge clk) begin
    logic signed [PROD_W-FRAC_BITS:0] sum;
    logic signed [COORD_W-1:0]        pt [3];
    if (adv) begin
      for (int a = 0; a < 3; a++) begin
        sum = (PROD_W-FRAC_BITS+1)'(m_prod[a] >>> FRAC_BITS)
            + (PROD_W-FRAC_BITS+1)'(m_o[a]);
        if (sum > $signed((PROD_W-FRAC_BITS+1)'({1'b0, {(COORD_W-1){1'b1}}})))
          pt[a] = {1'b0, {(COORD_W-1){1'b1}}};
        else if (sum < -$signed((PROD_W-FRAC_BITS+1)'({1'b1, {(COORD_W-1){1'b0}}})))
          pt[a] = {1'b1, {(COORD_W-1){1'b0}}};
        else
          pt[a] = sum[COORD_W-1:0];
      end
      if (m_hit) begin
        res.hit_found       <= 1'b1;
        res.hit_distance    <= m_t;
        res.face_axis       <= m_axis;
        res.normal_negative <= m_fneg;
        res.point_x         <= pt[0];
        res.point_y         <= pt[1];
        res.point_z         <= pt[2];
      end else begin
        res <= '0;
      end
    end
  end

endmodule

@@ src/rbs_slab_div.sv @@
// Pipelined slab distance dividers: six lanes, two quotient bits per stage.
// Depends on rbs_pkg; carries the ray word and zero-direction miss alongside.
module rbs_slab_div
  import rbs_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          adv,
  input  logic                          vld_i,
  input  ray_t                          ray_i,
  input  logic [HALF_W-1:0]             half,
  output logic                          vld_o,
  output ray_t                          ray_o,
  output logic                          zmiss_o,
  output logic [LANES-1:0]              qneg_o,
  output logic [LANES-1:0][NUM_W-1:0]   quo_o
);

  logic [DIV_STAGES:0]                vld;
  ray_t                               ray   [0:DIV_STAGES];
  logic                               zmiss [0:DIV_STAGES];
  logic [LANES-1:0]                   qneg  [0:DIV_STAGES];
  logic [LANES-1:0][MAG_W-1:0]        dv    [0:DIV_STAGES];
  div_st_t [LANES-1:0]                st    [0:DIV_STAGES];

  logic signed [COORD_W-1:0] o_in [3];
  logic signed [COORD_W-1:0] d_in [3];
  logic [LANES-1:0]          qneg_in;
  logic [LANES-1:0][MAG_W-1:0] dv_in;
  div_st_t [LANES-1:0]       st_in;
  logic                      zmiss_in;

  // Form numerator and divisor magnitudes for both slab planes of each axis
  always_comb begin
    logic signed [COORD_W+1:0] nlo, nhi, hs;
    logic [COORD_W+1:0]        mlo, mhi;
    logic [COORD_W-1:0]        dm;
    logic [COORD_W:0]          om;
    o_in[0] = ray_i.origin_x;    o_in[1] = ray_i.origin_y;    o_in[2] = ray_i.origin_z;
    d_in[0] = ray_i.direction_x; d_in[1] = ray_i.direction_y; d_in[2] = ray_i.direction_z;
    zmiss_in = 1'b0;
    hs = $signed({3'b000, half});
    for (int a = 0; a < 3; a++) begin
      nlo = -hs - (COORD_W+2)'(o_in[a]);
      nhi =  hs - (COORD_W+2)'(o_in[a]);
      mlo = nlo[COORD_W+1] ? COORD_W'(0) - nlo : nlo;
      mhi = nhi[COORD_W+1] ? COORD_W'(0) - nhi : nhi;
      dm  = d_in[a][COORD_W-1] ? -d_in[a] : d_in[a];
      dv_in[2*a]     = dm;
      dv_in[2*a+1]   = dm;
      qneg_in[2*a]   = nlo[COORD_W+1] ^ d_in[a][COORD_W-1];
      qneg_in[2*a+1] = nhi[COORD_W+1] ^ d_in[a][COORD_W-1];
      st_in[2*a]     = '{rem: '0, num: {mlo[MAG_W-1:0], FRAC_BITS'(0)}, quo: '0};
      st_in[2*a+1]   = '{rem: '0, num: {mhi[MAG_W-1:0], FRAC_BITS'(0)}, quo: '0};
      // zero direction: miss when the origin is outside the slab or on its edge
      om = o_in[a][COORD_W-1] ? (COORD_W+1)'(0) - (COORD_W+1)'(o_in[a])
                              : (COORD_W+1)'(o_in[a]);
      if (d_in[a] == '0 && om >= (COORD_W+1)'(half))
        zmiss_in = 1'b1;
    end
  end

  // Valid bits travel with the words
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[DIV_STAGES-1:0], vld_i};
    end
  end

  // Load, then advance two quotient bits per stage
  always_ff @(posedge clk) begin
    if (adv) begin
      ray[0]   <= ray_i;
      zmiss[0] <= zmiss_in;
      qneg[0]  <= qneg_in;
      dv[0]    <= dv_in;
      st[0]    <= st_in;
      for (int s = 1; s <= DIV_STAGES; s++) begin
        ray[s]   <= ray[s-1];
        zmiss[s] <= zmiss[s-1];
        qneg[s]  <= qneg[s-1];
        dv[s]    <= dv[s-1];
        for (int k = 0; k < LANES; k++) begin
          st[s][k] <= div_step(div_step(st[s-1][k], dv[s-1][k]), dv[s-1][k]);
        end
      end
    end
  end

  always_comb begin
    vld_o   = vld[DIV_STAGES];
    ray_o   = ray[DIV_STAGES];
    zmiss_o = zmiss[DIV_STAGES];
    qneg_o  = qneg[DIV_STAGES];
    for (int k = 0; k < LANES; k++) quo_o[k] = st[DIV_STAGES][k].quo;
  end

endmodule

@@ bench/tb.sv @@
// Testbench for ray_box_slab_intersect_top: directed rays, then random rays,
// each checked against an in-bench slab-test predictor. Depends on rbs_pkg.
`timescale 1ns / 1ps

module tb;
  import rbs_pkg::*;

  localparam int LATENCY    = 32;
  localparam int STALL_LIMIT = 20000;
  localparam int N_RANDOM   = 1950;

  logic              clk;
  logic              rst;
  logic              ray_valid;
  logic              ray_stall;
  ray_t              ray;
  logic              res_valid;
  logic              res_stall;
  res_t              res;
  logic              half_we;
  logic [HALF_W-1:0] half_data;

  ray_box_slab_intersect_top uut (
    .clk(clk), .rst(rst),
    .ray_valid(ray_valid), .ray_stall(ray_stall), .ray(ray),
    .res_valid(res_valid), .res_stall(res_stall), .res(res),
    .half_we(half_we), .half_data(half_data)
  );

  // Directed row: ray plus an optional typed-in result
  typedef struct {
    ray_t r;
    bit   fixed;
    res_t want;
  } row_t;

  logic [HALF_W-1:0] half_size;
  res_t              pending_hits[$];
  int                errors;
  int                idle_cycles;
  bit                recv_pause;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Predict one ray's result with exact 64-bit slab arithmetic
  function automatic res_t slab_hit(ray_t r, logic [HALF_W-1:0] hs);
    longint h, one, lo, hi, t1, t2, tmp, t, p, prod, mag;
    longint o[3], d[3], tf[3];
    bit     fv[3], fneg[3];
    bit     neg, hit;
    int     pick;
    longint smax, smin;
    res_t   out;
    h = longint'(hs);
    one = 64'sd65536;
    smax = 64'sd2147483647;
    smin = -64'sd2147483648;
    o[0] = r.origin_x; o[1] = r.origin_y; o[2] = r.origin_z;
    d[0] = r.direction_x; d[1] = r.direction_y; d[2] = r.direction_z;
    lo = r.t_min;
    hi = r.t_max;
    hit = 1;
    pick = -1;
    out = '0;
    for (int a = 0; a < 3; a++) begin
      fv[a] = 0; fneg[a] = 0; tf[a] = 0;
    end
    // narrow the window axis by axis
    for (int a = 0; a < 3 && hit; a++) begin
      if (d[a] != 0) begin
        t1 = ((-h - o[a]) * one) / d[a];
        t2 = ((h - o[a]) * one) / d[a];
        neg = 0;
        if (t2 < t1) begin
          tmp = t1; t1 = t2; t2 = tmp; neg = 1;
        end
        if (t1 > lo) begin
          tf[a] = t1; fneg[a] = neg;
        end else begin
          tf[a] = t2; fneg[a] = !neg;
        end
        fv[a] = 1;
        if (t1 > lo) lo = t1;
        if (t2 < hi) hi = t2;
      end else begin
        mag = (o[a] < 0) ? -o[a] : o[a];
        if (mag >= h) hit = 0;
      end
    end
    if (!hit || lo >= hi) return out;
    // prefer a face at the low end, then the high end
    for (int a = 0; a < 3 && pick < 0; a++)
      if (fv[a] && tf[a] == lo) pick = a;
    for (int a = 0; a < 3 && pick < 0; a++)
      if (fv[a] && tf[a] == hi) pick = a;
    if (pick < 0) return out;
    t = (tf[pick] > smax) ? smax : (tf[pick] < smin) ? smin : tf[pick];
    out.hit_found = 1'b1;
    out.hit_distance = t[31:0];
    out.face_axis = 2'(pick);
    out.normal_negative = fneg[pick];
    for (int a = 0; a < 3; a++) begin
      prod = t * d[a];
      p = o[a] + ((prod >= 0) ? (prod >>> 16) : -((-prod + one - 1) >>> 16));
      if (p > smax) p = smax;
      if (p < smin) p = smin;
      if (a == 0) out.point_x = p[31:0];
      if (a == 1) out.point_y = p[31:0];
      if (a == 2) out.point_z = p[31:0];
    end
    return out;
  endfunction

  // Random coordinate: mostly near the box, sometimes any word
  function automatic logic [31:0] coord_word();
    case ($urandom_range(0, 9))
      0: return $urandom();
      1: return 32'sd0;
      2: return {$urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff};
      default: return 32'($signed($urandom_range(0, 8 * 65536)) - 4 * 65536);
    endcase
  endfunction

  function automatic ray_t rand_ray();
    ray_t r;
    r.origin_x = coord_word();
    r.origin_y = coord_word();
    r.origin_z = coord_word();
    r.direction_x = coord_word();
    r.direction_y = coord_word();
    r.direction_z = coord_word();
    if ($urandom_range(0, 3) == 0) begin
      r.t_min = $urandom();
      r.t_max = $urandom();
    end else begin
      r.t_min = 32'($signed($urandom_range(0, 4 * 65536)) - 2 * 65536);
      r.t_max = 32'h7fff_ffff - $urandom_range(0, 65536 * 64);
    end
    return r;
  endfunction

  function automatic int gap_len();
    if ($urandom_range(0, 3) != 0) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  // Send one ray word and queue its expected result
  task automatic send_ray(ray_t r, bit fixed, res_t want);
    res_t pred;
    int   g;
    pred = slab_hit(r, half_size);
    if (fixed && pred != want) begin
      $error("directed row disagrees with predictor: %h vs %h", want, pred);
      errors++;
    end
    ray_valid <= 1'b1;
    ray <= r;
    do @(posedge clk); while (ray_stall);
    pending_hits.push_back(pred);
    // keep valid high for a back-to-back word, else drop it for the gap
    g = gap_len();
    if (g > 0) begin
      ray_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  // Wait for the pipeline to drain, then write the half size
  task automatic set_half(logic [HALF_W-1:0] v);
    ray_valid <= 1'b0;
    while (pending_hits.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
    half_we <= 1'b1;
    half_data <= v;
    half_size = v;
    @(posedge clk);
    half_we <= 1'b0;
  endtask

  // Receiver: stall on random cycles, never while recv_pause is set
  always @(posedge clk) begin
    if (rst) begin
      res_stall <= 1'b0;
    end else if (recv_pause) begin
      res_stall <= 1'b0;
    end else begin
      res_stall <= ($urandom_range(0, 3) == 0) ||
                   ($urandom_range(0, 199) == 0);
    end
  end

  // Compare each accepted result word with the oldest expectation
  always @(posedge clk) begin
    res_t want;
    if (!rst && res_valid && !res_stall) begin
      if (pending_hits.size() == 0) begin
        $error("result word with nothing expected: %h", res);
        errors++;
      end else begin
        want = pending_hits.pop_front();
        if (res.hit_found !== want.hit_found) begin
          $error("hit_found exp %0d got %0d", want.hit_found, res.hit_found);
          errors++;
        end
        if (res.hit_distance !== want.hit_distance) begin
          $error("hit_distance exp %0d got %0d", want.hit_distance, res.hit_distance);
          errors++;
        end
        if (res.face_axis !== want.face_axis) begin
          $error("face_axis exp %0d got %0d", want.face_axis, res.face_axis);
          errors++;
        end
        if (res.normal_negative !== want.normal_negative) begin
          $error("normal_negative exp %0d got %0d", want.normal_negative,
                 res.normal_negative);
          errors++;
        end
        if (res.point_x !== want.point_x) begin
          $error("point_x exp %0d got %0d", want.point_x, res.point_x);
          errors++;
        end
        if (res.point_y !== want.point_y) begin
          $error("point_y exp %0d got %0d", want.point_y, res.point_y);
          errors++;
        end
        if (res.point_z !== want.point_z) begin
          $error("point_z exp %0d got %0d", want.point_z, res.point_z);
          errors++;
        end
      end
    end
  end

  // Watchdog: count cycles with no word accepted on either channel
  always @(posedge clk) begin
    if (rst || (ray_valid && !ray_stall) || (res_valid && !res_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    row_t    rows[$];
    row_t    rw;
    ray_t    r;
    res_t    miss;
    int      done_flag;
    errors = 0;
    idle_cycles = 0;
    recv_pause = 0;
    rst = 1'b1;
    ray_valid = 1'b0;
    ray = '0;
    half_we = 1'b0;
    half_data = '0;
    half_size = 31'd65536;
    miss = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed rows: origin, direction, window
    // along +x from -2: enters the x = -1 face at t = 1
    rw.r = '{-32'sd131072, 0, 0, 32'sd65536, 0, 0, 0, 32'sd655360};
    rw.fixed = 1;
    rw.want = '{1'b1, 32'sd65536, AXIS_X, 1'b0, -32'sd65536, 0, 0};
    rows.push_back(rw);
    // zero direction and origin outside the slab: miss
    rw.r = '{0, 32'sd131072, 0, 32'sd65536, 0, 0, 0, 32'sd655360};
    rw.want = miss;
    rows.push_back(rw);
    // origin on the slab edge with zero direction: miss
    rw.r = '{0, 0, 32'sd65536, 0, 32'sd65536, 0, -32'sd655360, 32'sd655360};
    rows.push_back(rw);
    // all directions zero, origin inside: no face, miss
    rw.r = '{0, 0, 0, 0, 0, 0, -32'sd655360, 32'sd655360};
    rows.push_back(rw);
    // empty window
    rw.r = '{-32'sd131072, 0, 0, 32'sd65536, 0, 0, 32'sd655360, 0};
    rows.push_back(rw);
    rw.fixed = 0;
    // from inside along -z: exit face chosen
    rw.r = '{0, 0, 0, 0, 0, -32'sd65536, 0, 32'h7fffffff};
    rows.push_back(rw);
    // diagonal ray, equal candidates on several axes
    rw.r = '{-32'sd131072, -32'sd131072, -32'sd131072,
             32'sd65536, 32'sd65536, 32'sd65536, 0, 32'sd655360};
    rows.push_back(rw);
    // field extremes
    rw.r = '{32'h80000000, 32'h7fffffff, 32'h80000000,
             32'h7fffffff, 32'h80000000, 32'sd1, 32'h80000000, 32'h7fffffff};
    rows.push_back(rw);
    rw.r = '{32'h7fffffff, 32'h80000000, 32'h7fffffff,
             32'h80000000, 32'h7fffffff, -32'sd1, 32'h80000000, 32'h7fffffff};
    rows.push_back(rw);
    rw.r = '{-32'sd131072, 0, 0, 32'sd1, 32'sd1, 32'sd1, 32'h80000000, 32'h7fffffff};
    rows.push_back(rw);
    rw.r = '{32'hffffffff, 32'hffffffff, 32'hffffffff,
             32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff};
    rows.push_back(rw);
    foreach (rows[i]) send_ray(rows[i].r, rows[i].fixed, rows[i].want);

    // Random rays over several half sizes, extremes included
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_half(31'd65536);
        1: set_half(31'd0);
        2: set_half(31'h7fffffff);
        3: set_half(31'd1);
        default: set_half(31'($urandom_range(1, 8 * 65536)));
      endcase
      for (int i = 0; i < N_RANDOM / 6; i++) begin
        r = rand_ray();
        send_ray(r, 0, miss);
        // hold the sender until every result has come
        if (ph == 2 && i == 50) begin
          ray_valid <= 1'b0;
          recv_pause = (i % 2 == 0);
          while (pending_hits.size() != 0) @(posedge clk);
          recv_pause = 0;
        end
      end
    end

    ray_valid <= 1'b0;
    while (pending_hits.size() != 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);
    done_flag = errors;
    if (done_flag == 0 && pending_hits.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
